### design/blse_pkg.sv
// ---------------------------------------------------------------------------
// blse_pkg
// Shared types and constants of the bounded endian load/store core.
// ---------------------------------------------------------------------------
package blse_pkg;

  localparam int CfgW  = 13;
  localparam int OffW  = 32;
  localparam int NbW   = 4;
  localparam int DataW = 64;
  localparam int IdxW  = 2;

  localparam logic [IdxW-1:0] REG_VIEW_BASE       = 2'd0;
  localparam logic [IdxW-1:0] REG_VIEW_LENGTH     = 2'd1;
  localparam logic [IdxW-1:0] REG_BUFFER_ATTACHED = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_TYPE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RW,
    S_FIN
  } state_t;

  // upper bits set by sign extension of an (nm1+1)-byte value
  function automatic logic [DataW-1:0] ext_mask(input logic [2:0] nm1);
    logic [DataW-1:0] m;
    case (nm1)
      3'd0:    m = 64'hFFFF_FFFF_FFFF_FF00;
      3'd1:    m = 64'hFFFF_FFFF_FFFF_0000;
      3'd2:    m = 64'hFFFF_FFFF_FF00_0000;
      3'd3:    m = 64'hFFFF_FFFF_0000_0000;
      3'd4:    m = 64'hFFFF_FF00_0000_0000;
      3'd5:    m = 64'hFFFF_0000_0000_0000;
      3'd6:    m = 64'hFF00_0000_0000_0000;
      default: m = 64'h0;
    endcase
    return m;
  endfunction

endpackage

### design/blse_intf.sv
// ---------------------------------------------------------------------------
// blse channel interfaces
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface blse_req_if import blse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [OffW-1:0]  byte_offset;
  logic [NbW-1:0]   access_bytes;
  logic             little_endian;
  logic             sign_extend;
  logic [DataW-1:0] write_value;

  modport source (output valid, req_type, byte_offset, access_bytes, little_endian,
                  sign_extend, write_value, input ready);
  modport sink   (input valid, req_type, byte_offset, access_bytes, little_endian,
                  sign_extend, write_value, output ready);
endinterface

interface blse_rsp_if import blse_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic [1:0]       access_status;

  modport source (output valid, read_data, access_status, input ready);
  modport sink   (input valid, read_data, access_status, output ready);
endinterface

interface blse_cfg_if import blse_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] reg_index;
  logic [CfgW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### design/bounded_endian_load_store_core.sv
// ---------------------------------------------------------------------------
// bounded_endian_load_store_core
// Bounds-checked little/big endian load/store over a windowed byte store.
// ---------------------------------------------------------------------------
// After reset the core clears the store one byte per cycle and accepts no
// request meanwhile; register writes are taken at any time. A request of n
// bytes then occupies the core through the accept, a check step, n + 1 byte
// steps through the byte-wide store ports and a step that loads the response
// register; a faulting request skips the byte steps. The response register
// lets the next request enter while a response waits; the load step stalls
// while it is still full.
module bounded_endian_load_store_core import blse_pkg::*; #(
  parameter int STORE_BYTES = 4096
) (
  input logic        clk,
  input logic        rst,
  blse_req_if.sink   req,
  blse_rsp_if.source rsp,
  blse_cfg_if.sink   cfg
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [33:0]   STORE_LIM = 34'(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  state_t state, state_next;

  logic [CfgW-1:0]  view_base;
  logic [CfgW-1:0]  view_length;
  logic             buffer_attached;

  logic             is_write;
  logic [OffW-1:0]  offset;
  logic [NbW-1:0]   nbytes;
  logic             le;
  logic             sx;
  logic [DataW-1:0] shreg;
  logic [AW-1:0]    base_addr;
  logic [NbW-1:0]   cnt;
  logic [AW-1:0]    clr_addr;
  status_t          status;

  logic             out_valid;
  logic [DataW-1:0] out_data;
  status_t          out_status;

  logic [33:0]      end_rel;
  logic [33:0]      end_abs;
  status_t          chk_status;
  logic [NbW-1:0]   j4;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  logic [2:0]       nm1;
  logic [DataW-1:0] ld_val;
  logic [DataW-1:0] rsp_val;
  logic             out_free;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_base       <= '0;
      view_length     <= '0;
      buffer_attached <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_VIEW_BASE:       view_base       <= cfg.wdata;
        REG_VIEW_LENGTH:     view_length     <= cfg.wdata;
        REG_BUFFER_ATTACHED: buffer_attached <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  // bounds check
  always_comb begin
    end_rel = {3'b000, offset[OffW-2:0]} + 34'(nbytes);
    end_abs = end_rel + 34'(view_base);
    if (!buffer_attached) begin
      chk_status = ST_TYPE;
    end else if (offset[OffW-1] || nbytes == 4'd0 || nbytes > 4'd8 ||
                 end_rel > 34'(view_length) || end_abs > STORE_LIM) begin
      chk_status = ST_RANGE;
    end else begin
      chk_status = ST_OK;
    end
  end

  // byte step: order chosen so the shift register moves the same way for either endianness
  always_comb begin
    j4        = (le ^ !is_write) ? cnt : (nbytes - 4'd1 - cnt);
    mem_addr  = base_addr + AW'(j4[2:0]);
    mem_we    = (state == S_CLEAR) || (state == S_RW && is_write && cnt < nbytes);
    mem_waddr = (state == S_CLEAR) ? clr_addr : mem_addr;
    mem_wdata = (state == S_CLEAR) ? 8'h00 : shreg[7:0];
  end

  blse_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // response value
  always_comb begin
    nm1    = 3'(nbytes - 4'd1);
    ld_val = shreg;
    if (sx && nbytes != 4'd8 && shreg[{nm1, 3'b111}]) begin
      ld_val = shreg | ext_mask(nm1);
    end
    rsp_val  = (is_write || status != ST_OK) ? '0 : ld_val;
    out_free = !out_valid || rsp.ready;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_CHECK;
      S_CHECK: state_next = (chk_status == ST_OK) ? S_RW : S_FIN;
      S_RW:    if (cnt == nbytes) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      is_write <= req.req_type;
      offset   <= req.byte_offset;
      nbytes   <= req.access_bytes;
      le       <= req.little_endian;
      sx       <= req.sign_extend;
      shreg    <= req.req_type ? req.write_value : '0;
    end else if (state == S_RW) begin
      if (is_write) begin
        if (cnt < nbytes) shreg <= {8'h00, shreg[DataW-1:8]};
      end else if (cnt != 4'd0) begin
        shreg <= {shreg[DataW-9:0], mem_rdata};
      end
    end
    if (state == S_CHECK) begin
      status    <= chk_status;
      base_addr <= AW'(34'(view_base) + {3'b000, offset[OffW-2:0]});
      cnt       <= '0;
    end else if (state == S_RW) begin
      cnt <= cnt + 4'd1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_data   <= rsp_val;
      out_status <= status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = out_data;
  assign rsp.access_status = out_status;

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.access_status != ST_OK |-> rsp.read_data == '0)
    else $error("faulting response carries data");

  a_we_legal: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_CLEAR || (state == S_RW && is_write && status == ST_OK))
    else $error("store written outside clear or a good write");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_CHECK)
    else $error("accepted request not checked");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RW |-> cnt <= nbytes && nbytes <= 4'd8)
    else $error("byte step past access width");

endmodule

### design/blse_ram.sv
// ---------------------------------------------------------------------------
// blse_ram
// Byte-wide store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module blse_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_endian_load_store_core. A queue-fed driver
// issues load/store requests; each accepted transfer updates the local copy
// of the byte store (window registers are copied too) and queues the expected
// response. The monitor compares every response transfer, field by field,
// in order. Register writes happen only between phases, with the core drained.
// ---------------------------------------------------------------------------
module tb;
  import blse_pkg::*;

  localparam int STORE_BYTES = 4096;
  localparam int SAW         = $clog2(STORE_BYTES);
  localparam int IDLE_LIMIT  = 20000;
  localparam int END_CYCLES  = 30;
  localparam logic OP_READ   = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct {
    logic             req_type;
    logic [OffW-1:0]  byte_offset;
    logic [NbW-1:0]   access_bytes;
    logic             little_endian;
    logic             sign_extend;
    logic [DataW-1:0] write_value;
  } mem_req_t;

  typedef struct {
    logic [DataW-1:0] read_data;
    status_t          status;
  } mem_rsp_t;

  logic clk = 1'b0;
  logic rst;

  blse_req_if req_if ();
  blse_rsp_if rsp_if ();
  blse_cfg_if cfg_if ();

  bounded_endian_load_store_core #(.STORE_BYTES(STORE_BYTES)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the block state
  logic [7:0]      store_img [STORE_BYTES] = '{default: 8'h00};
  logic [CfgW-1:0] win_base;
  logic [CfgW-1:0] win_len;
  logic            buf_attached;

  mem_req_t pending_reqs[$];
  mem_rsp_t expected_rsps[$];
  mem_req_t cur_req;
  bit       no_idle;
  int       fail_cnt = 0;
  int       req_gap;
  int       rsp_hold;
  int       idle_cycles;

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // applies one access to the store copy and returns the response it gives
  function automatic mem_rsp_t load_store_access(input mem_req_t r);
    mem_rsp_t         res;
    longint unsigned  off;
    longint unsigned  nb;
    longint unsigned  addr;
    logic [DataW-1:0] data;
    res.read_data = '0;
    data = '0;
    nb = 64'(r.access_bytes);
    off = 64'(r.byte_offset[OffW-2:0]);
    if (!buf_attached) begin
      res.status = ST_TYPE;
    end else if (r.byte_offset[OffW-1] || nb < 64'd1 || nb > 64'd8 ||
                 off + nb > 64'(win_len) ||
                 64'(win_base) + off + nb > 64'(STORE_BYTES)) begin
      res.status = ST_RANGE;
    end else begin
      res.status = ST_OK;
      addr = 64'(win_base) + off;
      for (longint unsigned i = 0; i < nb; i++) begin
        if (r.req_type == OP_WRITE) begin
          if (r.little_endian)
            store_img[SAW'(addr + i)] = r.write_value[8*i +: 8];
          else
            store_img[SAW'(addr + i)] = r.write_value[8*(nb-1-i) +: 8];
        end else if (r.little_endian) begin
          data[8*i +: 8] = store_img[SAW'(addr + i)];
        end else begin
          data = {data[DataW-9:0], store_img[SAW'(addr + i)]};
        end
      end
      if (r.req_type == OP_READ) begin
        if (r.sign_extend && nb < 64'd8 && data[8*nb-1])
          data = data | ({DataW{1'b1}} << (8*nb));
        res.read_data = data;
      end
    end
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_gap = 0;
    end else if (!(req_if.valid && !req_if.ready)) begin
      if (req_if.valid)
        expected_rsps.push_back(load_store_access(cur_req));
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        req_if.req_type      <= cur_req.req_type;
        req_if.byte_offset   <= cur_req.byte_offset;
        req_if.access_bytes  <= cur_req.access_bytes;
        req_if.little_endian <= cur_req.little_endian;
        req_if.sign_extend   <= cur_req.sign_extend;
        req_if.write_value   <= cur_req.write_value;
        req_if.valid         <= 1'b1;
        req_gap = gap_len();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    mem_rsp_t exp_rsp;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rsp_hold = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response transfer: read_data %h access_status %0d",
                 rsp_if.read_data, rsp_if.access_status);
          fail_cnt++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_if.read_data !== exp_rsp.read_data) begin
            $error("read_data: expected %h, got %h", exp_rsp.read_data, rsp_if.read_data);
            fail_cnt++;
          end
          if (rsp_if.access_status !== exp_rsp.status) begin
            $error("access_status: expected %0d, got %0d", exp_rsp.status,
                   rsp_if.access_status);
            fail_cnt++;
          end
        end
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0)
          rsp_hold = gap_len();
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_VIEW_BASE:       win_base = val;
      REG_VIEW_LENGTH:     win_len = val;
      REG_BUFFER_ATTACHED: buf_attached = val[0];
      default: ;
    endcase
  endtask

  task automatic push_req(input logic op, input logic [OffW-1:0] off,
                          input logic [NbW-1:0] nb, input logic le, input logic sx,
                          input logic [DataW-1:0] wv);
    mem_req_t r;
    r.req_type      = op;
    r.byte_offset   = off;
    r.access_bytes  = nb;
    r.little_endian = le;
    r.sign_extend   = sx;
    r.write_value   = wv;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
  endtask

  // mostly in-window accesses, some at the window edge, some negative or huge
  function automatic mem_req_t rand_request();
    mem_req_t r;
    int       pick;
    int       o;
    r.req_type      = 1'($urandom_range(0, 1));
    r.little_endian = 1'($urandom_range(0, 1));
    r.sign_extend   = 1'($urandom_range(0, 1));
    r.write_value   = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 70)
      r.access_bytes = 4'd1 << $urandom_range(0, 3);
    else if (pick < 92)
      r.access_bytes = 4'($urandom_range(1, 8));
    else if (pick < 95)
      r.access_bytes = 4'd0;
    else
      r.access_bytes = 4'($urandom_range(9, 15));
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      r.byte_offset = $urandom_range(0, int'(win_len));
    end else if (pick < 85) begin
      o = int'(win_len) - int'(r.access_bytes) + int'($urandom_range(0, 2));
      r.byte_offset = o;
    end else if (pick < 93) begin
      r.byte_offset = {1'b1, 31'($urandom)};
    end else begin
      r.byte_offset = $urandom;
    end
    return r;
  endfunction

  task automatic run_phase(input int base, input int len, input bit att, input bit quiet,
                           input int count);
    write_reg(REG_VIEW_BASE, CfgW'(base));
    write_reg(REG_VIEW_LENGTH, CfgW'(len));
    write_reg(REG_BUFFER_ATTACHED, CfgW'(att));
    no_idle = quiet;
    for (int i = 0; i < count; i++)
      pending_reqs.push_back(rand_request());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    no_idle = 1'b0;
    win_base = '0;
    win_len = '0;
    buf_attached = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = REG_VIEW_BASE;
    cfg_if.wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset registers: no buffer, type error wins over any range fault
    push_req(OP_READ, 32'd0, 4'd4, 1'b1, 1'b0, '0);
    push_req(OP_WRITE, 32'd0, 4'd8, 1'b0, 1'b0, '1);
    push_req(OP_READ, 32'hFFFF_FFF0, 4'd2, 1'b1, 1'b1, '0);
    push_req(OP_WRITE, 32'd0, 4'd0, 1'b1, 1'b0, '1);
    drain();

    write_reg(REG_VIEW_BASE, '0);
    write_reg(REG_VIEW_LENGTH, CfgW'(STORE_BYTES));
    write_reg(REG_BUFFER_ATTACHED, CfgW'(1));
    push_req(OP_WRITE, 32'd0, 4'd8, 1'b1, 1'b0, 64'hF0E1_D2C3_B4A5_9687);
    push_req(OP_READ, 32'd0, 4'd8, 1'b1, 1'b0, '0);
    push_req(OP_READ, 32'd0, 4'd8, 1'b0, 1'b1, '0);
    push_req(OP_READ, 32'd7, 4'd1, 1'b1, 1'b1, '0);
    push_req(OP_READ, 32'd4, 4'd4, 1'b0, 1'b1, '0);
    push_req(OP_READ, 32'd2, 4'd2, 1'b1, 1'b0, '0);
    push_req(OP_READ, 32'd1, 4'd3, 1'b0, 1'b1, '0);
    push_req(OP_WRITE, 32'd4088, 4'd8, 1'b0, 1'b1, 64'h8000_0000_0000_0001);
    push_req(OP_READ, 32'd4092, 4'd4, 1'b1, 1'b1, '0);
    push_req(OP_READ, 32'd4089, 4'd8, 1'b1, 1'b0, '0);
    push_req(OP_WRITE, 32'hFFFF_FFFF, 4'd1, 1'b1, 1'b0, '1);
    push_req(OP_READ, 32'h8000_0000, 4'd4, 1'b1, 1'b0, '0);
    push_req(OP_READ, 32'h7FFF_FFFF, 4'd1, 1'b1, 1'b0, '0);
    push_req(OP_WRITE, 32'd0, 4'd0, 1'b1, 1'b0, '1);
    push_req(OP_READ, 32'd0, 4'd9, 1'b1, 1'b0, '0);
    push_req(OP_WRITE, 32'd0, 4'd15, 1'b0, 1'b0, '1);
    push_req(OP_READ, 32'd0, 4'd8, 1'b1, 1'b0, '0);
    push_req(OP_WRITE, 32'd100, 4'd1, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FF80);
    push_req(OP_READ, 32'd100, 4'd1, 1'b0, 1'b1, '0);
    push_req(OP_READ, 32'd100, 4'd1, 1'b0, 1'b0, '0);
    push_req(OP_READ, 32'd4095, 4'd1, 1'b1, 1'b1, '0);
    drain();

    run_phase(0, STORE_BYTES, 1'b1, 1'b0, 250);
    run_phase(100, 32, 1'b1, 1'b0, 250);
    run_phase(4080, 64, 1'b1, 1'b1, 200);
    run_phase(8191, 8191, 1'b1, 1'b0, 100);
    run_phase(0, 0, 1'b1, 1'b0, 60);
    run_phase(3000, 8191, 1'b1, 1'b0, 200);
    run_phase(512, 16, 1'b0, 1'b0, 60);
    run_phase($urandom_range(0, STORE_BYTES - 1), $urandom_range(1, 64), 1'b1, 1'b0, 250);
    run_phase(4095, 1, 1'b1, 1'b0, 200);
    run_phase(2048, 128, 1'b1, 1'b0, 300);

    repeat (END_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
